@@ sv/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg: shared definitions for the point-on-triangle projection block
// Item kind codes, default number format and the cosine threshold constants.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int KIND_WIDTH      = 3;

   localparam logic [KIND_WIDTH-1:0] KIND_VERTEX_A = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_VERTEX_B = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_VERTEX_C = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_NORMAL   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY    = 3'd4;

   // Cosine threshold 99/100, squared on both sides of the compare.
   localparam int COS_CONST_WIDTH = 14;
   localparam int COS_DEN_SQ      = 10000;
   localparam int COS_NUM_SQ      = 9801;

endpackage

@@ sv/ppt_ifs.sv @@
// ----------------------------------------------------------------------------
// ppt channel interfaces
// Valid/ready channels for query and load transactions and for results.
// ----------------------------------------------------------------------------
interface ppt_req_if
   import ppt_pkg::*;
   #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic [KIND_WIDTH-1:0]         kind;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;
   logic signed [COORD_WIDTH-1:0] z_coord;

   modport source (output valid, kind, x_coord, y_coord, z_coord, input ready);
   modport sink   (input valid, kind, x_coord, y_coord, z_coord, output ready);
endinterface

interface ppt_rsp_if
   import ppt_pkg::*;
   #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] proj_x;
   logic signed [COORD_WIDTH-1:0] proj_y;
   logic signed [COORD_WIDTH-1:0] proj_z;
   logic                          inside_res;

   modport source (output valid, proj_x, proj_y, proj_z, inside_res, input ready);
   modport sink   (input valid, proj_x, proj_y, proj_z, inside_res, output ready);
endinterface

@@ sv/project_point_on_triangle.sv @@
// ----------------------------------------------------------------------------
// project_point_on_triangle
// Projects query points onto a stored plane and tests them against a
// stored triangle, in a fourteen-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel    Direction  Transaction
//  req_chan   in         load of vertex A/B/C or plane normal, or a query point
//  rsp_chan   out        projected point and inside flag, one per query
//
// A transaction is taken in every cycle in which the output stage is empty or
// its result is being taken; a query's result passes through stages 1 to 14
// and is presented from the stage-14 output register. The sustained rate is
// one query per cycle while results are taken; the depth is set by the chain
// of rounded products and the split wide squares of the cosine test.
// Loads update the triangle at once and give no result; each query carries a
// copy of the triangle and normal with it, so later loads never disturb it.
// Reset clears the stored triangle, the normal and all stage valid bits.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module project_point_on_triangle
   import ppt_pkg::*;
   #(parameter int COORD_WIDTH = COORD_WIDTH_DEF,
     parameter int FRAC_BITS   = FRAC_BITS_DEF)
   (input logic     clock,
    input logic     reset,
    ppt_req_if.sink req_chan,
    ppt_rsp_if.source rsp_chan);

   localparam int W  = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int P2 = 2 * W;
   localparam int NS = 14;
   localparam int WW = 2 * P2 + COS_CONST_WIDTH;

   typedef logic signed [W-1:0]    crd_type;
   typedef logic signed [W+1:0]    ext_type;
   typedef logic signed [P2-1:0]   prod_type;
   typedef logic signed [P2+1:0]   dsum_type;
   typedef logic [P2-1:0]          mag_type;
   typedef logic [2*P2-1:0]        sq_type;
   typedef logic [WW-1:0]          wide_type;

   // Operand pairs for the exact dot products of the edge normals:
   // n1.n2, n1.n1, n2.n2, n2.n3, n3.n3.
   localparam int PA [5] = '{0, 0, 1, 1, 2};
   localparam int PB [5] = '{1, 0, 1, 2, 2};
   // Pairs for the squares: d12^2, |n1|^2|n2|^2, d23^2, |n2|^2|n3|^2.
   localparam int QA [4] = '{0, 1, 3, 2};
   localparam int QB [4] = '{0, 2, 3, 4};

   // Clamp a widened sum back into the coordinate range.
   function automatic crd_type sat_ext(ext_type x);
      ext_type hi;
      ext_type lo;
      hi = $signed({3'b000, {(W-1){1'b1}}});
      lo = $signed({3'b111, {(W-1){1'b0}}});
      if (x > hi) begin
         return crd_type'(hi);
      end else if (x < lo) begin
         return crd_type'(lo);
      end
      return crd_type'(x);
   endfunction

   function automatic crd_type sat_sub(crd_type a, crd_type b);
      return sat_ext(ext_type'(a) - ext_type'(b));
   endfunction

   // Round an exact product to F fraction bits, half away from zero, saturated.
   function automatic crd_type qround(prod_type p);
      logic [P2-1:0] m;
      logic [P2:0]   r;
      logic [P2:0]   lim;
      logic [W-1:0]  rw;
      m   = p[P2-1] ? mag_type'(~p + 1'b1) : mag_type'(p);
      r   = ({1'b0, m} + ((P2+1)'(1) << (F-1))) >> F;
      lim = p[P2-1] ? ((P2+1)'(1) << (W-1)) : (((P2+1)'(1) << (W-1)) - 1'b1);
      if (r > lim) begin
         r = lim;
      end
      rw = r[W-1:0];
      return p[P2-1] ? crd_type'(~rw + 1'b1) : crd_type'(rw);
   endfunction

   // Pipeline control: every stage advances together unless the result stalls.
   logic          en;
   logic          req_acc;
   logic          query_acc;
   logic [NS-1:0] valid_ff, valid_in;
   crd_type       in_q [3];

   // Stored triangle and plane normal.
   crd_type a_ff [3], a_in [3];
   crd_type b_ff [3], b_in [3];
   crd_type c_ff [3], c_in [3];
   crd_type nrm_ff [3], nrm_in [3];

   // Stages 1 to 5: projection onto the plane.
   crd_type  s1_q_ff [3], s1_q_in [3], s1_d_ff [3], s1_d_in [3];
   crd_type  s1_a_ff [3], s1_a_in [3], s1_b_ff [3], s1_b_in [3];
   crd_type  s1_c_ff [3], s1_c_in [3], s1_n_ff [3], s1_n_in [3];
   crd_type  s2_q_ff [3], s2_q_in [3], s2_n_ff [3], s2_n_in [3];
   crd_type  s2_a_ff [3], s2_a_in [3], s2_b_ff [3], s2_b_in [3];
   crd_type  s2_c_ff [3], s2_c_in [3];
   prod_type s2_pr_ff [3], s2_pr_in [3];
   crd_type  s3_q_ff [3], s3_q_in [3], s3_n_ff [3], s3_n_in [3];
   crd_type  s3_a_ff [3], s3_a_in [3], s3_b_ff [3], s3_b_in [3];
   crd_type  s3_c_ff [3], s3_c_in [3];
   crd_type  s3_dot_ff, s3_dot_in;
   crd_type  s4_q_ff [3], s4_q_in [3];
   crd_type  s4_a_ff [3], s4_a_in [3], s4_b_ff [3], s4_b_in [3];
   crd_type  s4_c_ff [3], s4_c_in [3];
   prod_type s4_pr_ff [3], s4_pr_in [3];
   crd_type  s5_p_ff [3], s5_p_in [3];
   crd_type  s5_a_ff [3], s5_a_in [3], s5_b_ff [3], s5_b_in [3];
   crd_type  s5_c_ff [3], s5_c_in [3];

   // Stages 6 to 8: edge normals.
   crd_type  e0 [3][3], e1 [3][3];
   crd_type  s6_p_ff [3], s6_p_in [3];
   crd_type  s6_u_ff [3][3], s6_u_in [3][3], s6_v_ff [3][3], s6_v_in [3][3];
   crd_type  s7_p_ff [3], s7_p_in [3];
   prod_type s7_pm_ff [3][6], s7_pm_in [3][6];
   crd_type  s8_p_ff [3], s8_p_in [3];
   crd_type  s8_nv_ff [3][3], s8_nv_in [3][3];

   // Stages 9 to 14: cosine tests.
   crd_type  s9_p_ff [3], s9_p_in [3];
   prod_type s9_dp_ff [5][3], s9_dp_in [5][3];
   dsum_type dsum [5];
   crd_type  s10_p_ff [3], s10_p_in [3];
   mag_type  s10_mg_ff [5], s10_mg_in [5];
   logic     s10_f1_ff, s10_f1_in, s10_f2_ff, s10_f2_in;
   crd_type  s11_p_ff [3], s11_p_in [3];
   mag_type  s11_pp_ff [4][4], s11_pp_in [4][4];
   logic     s11_f1_ff, s11_f1_in, s11_f2_ff, s11_f2_in;
   crd_type  s12_p_ff [3], s12_p_in [3];
   sq_type   s12_sq_ff [4], s12_sq_in [4];
   logic     s12_f1_ff, s12_f1_in, s12_f2_ff, s12_f2_in;
   crd_type  s13_p_ff [3], s13_p_in [3];
   wide_type s13_l1_ff, s13_l1_in, s13_r1_ff, s13_r1_in;
   wide_type s13_l2_ff, s13_l2_in, s13_r2_ff, s13_r2_in;
   logic     s13_f1_ff, s13_f1_in, s13_f2_ff, s13_f2_in;
   crd_type  s14_p_ff [3], s14_p_in [3];
   logic     s14_in_ff, s14_in_in;

   assign en        = !valid_ff[NS-1] || rsp_chan.ready;
   assign req_acc   = req_chan.valid && en;
   assign query_acc = req_acc && (req_chan.kind == KIND_QUERY);
   assign in_q[0]   = req_chan.x_coord;
   assign in_q[1]   = req_chan.y_coord;
   assign in_q[2]   = req_chan.z_coord;

   // Loads write the stored triangle at once; unused kinds change nothing.
   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      nrm_in = nrm_ff;
      if (req_acc) begin
         case (req_chan.kind)
            KIND_VERTEX_A: a_in   = in_q;
            KIND_VERTEX_B: b_in   = in_q;
            KIND_VERTEX_C: c_in   = in_q;
            KIND_NORMAL:   nrm_in = in_q;
            default: begin
            end
         endcase
      end
      valid_in = en ? {valid_ff[NS-2:0], query_acc} : valid_ff;
   end

   // Projection: offset from A, dot with the normal, then pull back along it.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_q_in[i] = in_q[i];
         s1_d_in[i] = sat_sub(in_q[i], a_ff[i]);
         s2_pr_in[i] = s1_d_ff[i] * s1_n_ff[i];
         s4_pr_in[i] = s3_dot_ff * s3_n_ff[i];
         s5_p_in[i] = sat_sub(s4_q_ff[i], qround(s4_pr_ff[i]));
      end
      s1_a_in = a_ff;   s1_b_in = b_ff;   s1_c_in = c_ff;   s1_n_in = nrm_ff;
      s2_q_in = s1_q_ff; s2_a_in = s1_a_ff; s2_b_in = s1_b_ff;
      s2_c_in = s1_c_ff; s2_n_in = s1_n_ff;
      s3_q_in = s2_q_ff; s3_a_in = s2_a_ff; s3_b_in = s2_b_ff;
      s3_c_in = s2_c_ff; s3_n_in = s2_n_ff;
      s3_dot_in = sat_ext(ext_type'(qround(s2_pr_ff[0])) + ext_type'(qround(s2_pr_ff[1]))
                          + ext_type'(qround(s2_pr_ff[2])));
      s4_q_in = s3_q_ff; s4_a_in = s3_a_ff; s4_b_in = s3_b_ff; s4_c_in = s3_c_ff;
      s5_a_in = s4_a_ff; s5_b_in = s4_b_ff; s5_c_in = s4_c_ff;
   end

   // Edge normals (e1 - e0) x (p - e0) for the edges AB, BC and CA.
   always_comb begin
      e0[0] = s5_a_ff; e1[0] = s5_b_ff;
      e0[1] = s5_b_ff; e1[1] = s5_c_ff;
      e0[2] = s5_c_ff; e1[2] = s5_a_ff;
      for (int e = 0; e < 3; e++) begin
         for (int i = 0; i < 3; i++) begin
            s6_u_in[e][i] = sat_sub(e1[e][i], e0[e][i]);
            s6_v_in[e][i] = sat_sub(s5_p_ff[i], e0[e][i]);
         end
         s7_pm_in[e][0] = s6_u_ff[e][1] * s6_v_ff[e][2];
         s7_pm_in[e][1] = s6_u_ff[e][2] * s6_v_ff[e][1];
         s7_pm_in[e][2] = s6_u_ff[e][2] * s6_v_ff[e][0];
         s7_pm_in[e][3] = s6_u_ff[e][0] * s6_v_ff[e][2];
         s7_pm_in[e][4] = s6_u_ff[e][0] * s6_v_ff[e][1];
         s7_pm_in[e][5] = s6_u_ff[e][1] * s6_v_ff[e][0];
         for (int k = 0; k < 3; k++) begin
            s8_nv_in[e][k] = sat_sub(qround(s7_pm_ff[e][2*k]), qround(s7_pm_ff[e][2*k+1]));
         end
      end
      s6_p_in = s5_p_ff;
      s7_p_in = s6_p_ff;
      s8_p_in = s7_p_ff;
   end

   // Cosine tests: exact dots, split squares, scaled by the squared threshold.
   always_comb begin
      for (int j = 0; j < 5; j++) begin
         for (int i = 0; i < 3; i++) begin
            s9_dp_in[j][i] = s8_nv_ff[PA[j]][i] * s8_nv_ff[PB[j]][i];
         end
         dsum[j] = dsum_type'(s9_dp_ff[j][0]) + dsum_type'(s9_dp_ff[j][1])
                   + dsum_type'(s9_dp_ff[j][2]);
         s10_mg_in[j] = dsum[j][P2-1:0];
      end
      // A positive dot fits in P2 bits, and so does each squared length.
      s10_f1_in = !dsum[0][P2+1] && (dsum[0] != '0) && (dsum[1] != '0) && (dsum[2] != '0);
      s10_f2_in = !dsum[3][P2+1] && (dsum[3] != '0) && (dsum[2] != '0) && (dsum[4] != '0);
      for (int k = 0; k < 4; k++) begin
         s11_pp_in[k][0] = s10_mg_ff[QA[k]][W-1:0]  * s10_mg_ff[QB[k]][W-1:0];
         s11_pp_in[k][1] = s10_mg_ff[QA[k]][W-1:0]  * s10_mg_ff[QB[k]][P2-1:W];
         s11_pp_in[k][2] = s10_mg_ff[QA[k]][P2-1:W] * s10_mg_ff[QB[k]][W-1:0];
         s11_pp_in[k][3] = s10_mg_ff[QA[k]][P2-1:W] * s10_mg_ff[QB[k]][P2-1:W];
         s12_sq_in[k] = (sq_type'(s11_pp_ff[k][3]) << P2) + (sq_type'(s11_pp_ff[k][1]) << W)
                        + (sq_type'(s11_pp_ff[k][2]) << W) + sq_type'(s11_pp_ff[k][0]);
      end
      s13_l1_in = wide_type'(s12_sq_ff[0]) * wide_type'(COS_DEN_SQ);
      s13_r1_in = wide_type'(s12_sq_ff[1]) * wide_type'(COS_NUM_SQ);
      s13_l2_in = wide_type'(s12_sq_ff[2]) * wide_type'(COS_DEN_SQ);
      s13_r2_in = wide_type'(s12_sq_ff[3]) * wide_type'(COS_NUM_SQ);
      s14_in_in = s13_f1_ff && (s13_l1_ff > s13_r1_ff) && s13_f2_ff && (s13_l2_ff > s13_r2_ff);
      s11_f1_in = s10_f1_ff; s11_f2_in = s10_f2_ff;
      s12_f1_in = s11_f1_ff; s12_f2_in = s11_f2_ff;
      s13_f1_in = s12_f1_ff; s13_f2_in = s12_f2_ff;
      s9_p_in  = s8_p_ff;  s10_p_in = s9_p_ff;  s11_p_in = s10_p_ff;
      s12_p_in = s11_p_ff; s13_p_in = s12_p_ff; s14_p_in = s13_p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         a_ff     <= '{default: '0};
         b_ff     <= '{default: '0};
         c_ff     <= '{default: '0};
         nrm_ff   <= '{default: '0};
      end else begin
         valid_ff <= valid_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         nrm_ff   <= nrm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_q_ff <= s1_q_in; s1_d_ff <= s1_d_in; s1_a_ff <= s1_a_in;
         s1_b_ff <= s1_b_in; s1_c_ff <= s1_c_in; s1_n_ff <= s1_n_in;
         s2_q_ff <= s2_q_in; s2_n_ff <= s2_n_in; s2_a_ff <= s2_a_in;
         s2_b_ff <= s2_b_in; s2_c_ff <= s2_c_in; s2_pr_ff <= s2_pr_in;
         s3_q_ff <= s3_q_in; s3_n_ff <= s3_n_in; s3_a_ff <= s3_a_in;
         s3_b_ff <= s3_b_in; s3_c_ff <= s3_c_in; s3_dot_ff <= s3_dot_in;
         s4_q_ff <= s4_q_in; s4_a_ff <= s4_a_in; s4_b_ff <= s4_b_in;
         s4_c_ff <= s4_c_in; s4_pr_ff <= s4_pr_in;
         s5_p_ff <= s5_p_in; s5_a_ff <= s5_a_in; s5_b_ff <= s5_b_in; s5_c_ff <= s5_c_in;
         s6_p_ff <= s6_p_in; s6_u_ff <= s6_u_in; s6_v_ff <= s6_v_in;
         s7_p_ff <= s7_p_in; s7_pm_ff <= s7_pm_in;
         s8_p_ff <= s8_p_in; s8_nv_ff <= s8_nv_in;
         s9_p_ff <= s9_p_in; s9_dp_ff <= s9_dp_in;
         s10_p_ff <= s10_p_in; s10_mg_ff <= s10_mg_in;
         s10_f1_ff <= s10_f1_in; s10_f2_ff <= s10_f2_in;
         s11_p_ff <= s11_p_in; s11_pp_ff <= s11_pp_in;
         s11_f1_ff <= s11_f1_in; s11_f2_ff <= s11_f2_in;
         s12_p_ff <= s12_p_in; s12_sq_ff <= s12_sq_in;
         s12_f1_ff <= s12_f1_in; s12_f2_ff <= s12_f2_in;
         s13_p_ff <= s13_p_in; s13_l1_ff <= s13_l1_in; s13_r1_ff <= s13_r1_in;
         s13_l2_ff <= s13_l2_in; s13_r2_ff <= s13_r2_in;
         s13_f1_ff <= s13_f1_in; s13_f2_ff <= s13_f2_in;
         s14_p_ff <= s14_p_in; s14_in_ff <= s14_in_in;
      end
   end

   // The last stage is the output register.
   assign req_chan.ready      = en;
   assign rsp_chan.valid      = valid_ff[NS-1];
   assign rsp_chan.proj_x     = s14_p_ff[0];
   assign rsp_chan.proj_y     = s14_p_ff[1];
   assign rsp_chan.proj_z     = s14_p_ff[2];
   assign rsp_chan.inside_res = s14_in_ff;

`ifndef NO_ASSERTIONS
   // A stalled result freezes every stage's valid bit.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS-1] && !rsp_chan.ready |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

   // An accepted query occupies the first stage in the next cycle.
   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.kind == KIND_QUERY) |=> valid_ff[0])
      else $error("accepted query did not enter the pipeline");

   // Loads and unused kinds never start a result.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.kind != KIND_QUERY) |=> !valid_ff[0])
      else $error("non-query transaction entered the pipeline");
`endif

endmodule
